FILE: sv/dcq_pkg.sv
// Shared types, widths and codes for the delta-clock event queue.
package dcq_pkg;

    // Default number of queue entries
    localparam int CAPACITY_DEF = 16;

    // Field widths of the request and result items
    localparam int DELAY_W = 16;
    localparam int ID_W    = 8;
    localparam int TICK_W  = 16;
    localparam int KIND_W  = 2;

    // Operation codes
    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_OK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIRED = 2'd2;

    typedef logic [DELAY_W-1:0] t_delay;
    typedef logic [ID_W-1:0]    t_id;

    typedef struct packed {
        logic              op;
        t_delay            delay;
        t_id               event_id;
        logic [TICK_W-1:0] tick_count;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        t_id               fired_id;
        logic              last;
    } t_out_item;

    // Port enables of the entry memories
    typedef struct packed {
        logic rd_en;
        logic dw_en;
        logic nw_en;
    } t_mem_ctl;

endpackage

FILE: sv/dcq_store.sv
// Entry memories of the queue: delta memory and node memory (id and link).
module dcq_store #(
    parameter int CAPACITY = dcq_pkg::CAPACITY_DEF,
    localparam int IDX_W = $clog2(CAPACITY)
) (
    input  logic                     i_clk,
    input  dcq_pkg::t_mem_ctl        i_ctl,
    input  logic [IDX_W-1:0]         i_rd_addr,
    input  logic [IDX_W-1:0]         i_dw_addr,
    input  dcq_pkg::t_delay          i_dw_data,
    input  logic [IDX_W-1:0]         i_nw_addr,
    input  dcq_pkg::t_id             i_nw_id,
    input  logic [IDX_W-1:0]         i_nw_link,
    output dcq_pkg::t_delay          o_rd_delta,
    output dcq_pkg::t_id             o_rd_id,
    output logic [IDX_W-1:0]         o_rd_link
);
    import dcq_pkg::*;

    logic [DELAY_W-1:0]    r_delta_mem [CAPACITY];
    logic [ID_W+IDX_W-1:0] r_node_mem  [CAPACITY];
    logic [DELAY_W-1:0]    r_rd_delta;
    logic [ID_W+IDX_W-1:0] r_rd_node;

    // Write delta memory
    always_ff @(posedge i_clk) begin
        if (i_ctl.dw_en) begin
            r_delta_mem[i_dw_addr] <= i_dw_data;
        end
    end

    // Write node memory
    always_ff @(posedge i_clk) begin
        if (i_ctl.nw_en) begin
            r_node_mem[i_nw_addr] <= {i_nw_id, i_nw_link};
        end
    end

    // Read both memories at one address; hold the data while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_delta <= r_delta_mem[i_rd_addr];
            r_rd_node  <= r_node_mem[i_rd_addr];
        end
    end

    assign o_rd_delta = r_rd_delta;
    assign o_rd_id    = r_rd_node[ID_W+IDX_W-1:IDX_W];
    assign o_rd_link  = r_rd_node[IDX_W-1:0];

endmodule

FILE: sv/dcq_ctrl.sv
// Sequencer of the queue: list walk for insert, firing loop for advance.
module dcq_ctrl #(
    parameter int CAPACITY = dcq_pkg::CAPACITY_DEF,
    localparam int IDX_W = $clog2(CAPACITY),
    localparam int CNT_W = $clog2(CAPACITY + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  dcq_pkg::t_in_item        i_in_data,
    input  logic                     i_out_free,
    output logic                     o_emit,
    output dcq_pkg::t_out_item       o_emit_item,
    output dcq_pkg::t_mem_ctl        o_ctl,
    output logic [IDX_W-1:0]         o_rd_addr,
    output logic [IDX_W-1:0]         o_dw_addr,
    output dcq_pkg::t_delay          o_dw_data,
    output logic [IDX_W-1:0]         o_nw_addr,
    output dcq_pkg::t_id             o_nw_id,
    output logic [IDX_W-1:0]         o_nw_link,
    input  dcq_pkg::t_delay          i_rd_delta,
    input  dcq_pkg::t_id             i_rd_id,
    input  logic [IDX_W-1:0]         i_rd_link,
    output logic [CNT_W-1:0]         o_count,
    output logic [CAPACITY-1:0]      o_free
);
    import dcq_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_PLACE = 3'd2;
    localparam logic [2:0] S_ADV   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]          r_state,   n_state;
    logic [IDX_W-1:0]    r_head,    n_head;
    logic [IDX_W-1:0]    r_cur,     n_cur;
    logic [IDX_W-1:0]    r_prev,    n_prev;
    logic [IDX_W-1:0]    r_slot,    n_slot;
    logic [ID_W-1:0]     r_prev_id, n_prev_id;
    logic [ID_W-1:0]     r_id,      n_id;
    logic [ID_W-1:0]     r_pend_id, n_pend_id;
    logic [DELAY_W-1:0]  r_rem,     n_rem;
    logic [DELAY_W-1:0]  r_ticks,   n_ticks;
    logic [CNT_W-1:0]    r_count,   n_count;
    logic [CNT_W-1:0]    r_seen,    n_seen;
    logic [CAPACITY-1:0] r_free,    n_free;
    logic                r_at_head, n_at_head;
    logic                r_pend,    n_pend;
    logic [KIND_W-1:0]   r_kind,    n_kind;

    logic [IDX_W-1:0]    w_slot;
    logic [CNT_W-1:0]    w_seen_nx;

    // Pick the lowest free entry
    always_comb begin
        w_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                w_slot = IDX_W'(i);
            end
        end
    end

    assign w_seen_nx = r_seen + CNT_W'(1);

    // Next state, memory requests and result emission
    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_cur     = r_cur;
        n_prev    = r_prev;
        n_slot    = r_slot;
        n_prev_id = r_prev_id;
        n_id      = r_id;
        n_pend_id = r_pend_id;
        n_rem     = r_rem;
        n_ticks   = r_ticks;
        n_count   = r_count;
        n_seen    = r_seen;
        n_free    = r_free;
        n_at_head = r_at_head;
        n_pend    = r_pend;
        n_kind    = r_kind;

        o_ctl       = '0;
        o_rd_addr   = r_head;
        o_dw_addr   = r_cur;
        o_dw_data   = '0;
        o_nw_addr   = r_slot;
        o_nw_id     = r_id;
        o_nw_link   = r_cur;
        o_emit      = 1'b0;
        o_emit_item = '{kind: KIND_FIRED, fired_id: r_pend_id, last: 1'b0};

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.op == OP_INSERT) begin
                        n_id      = i_in_data.event_id;
                        n_rem     = i_in_data.delay;
                        n_cur     = r_head;
                        n_seen    = '0;
                        n_at_head = 1'b1;
                        n_slot    = w_slot;
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_kind  = KIND_FULL;
                            n_state = S_EMIT;
                        end else if (r_count == '0) begin
                            n_state = S_PLACE;
                        end else begin
                            o_ctl.rd_en = 1'b1;
                            o_rd_addr   = r_head;
                            n_state     = S_WALK;
                        end
                    end else begin
                        n_ticks = DELAY_W'(i_in_data.tick_count);
                        n_cur   = r_head;
                        n_pend  = 1'b0;
                        if (i_in_data.tick_count != '0 && r_count != '0) begin
                            o_ctl.rd_en = 1'b1;
                            o_rd_addr   = r_head;
                            n_state     = S_ADV;
                        end
                    end
                end
            end

            S_WALK: begin
                if (r_rem > i_rd_delta) begin
                    // Pass this entry and take its delta off the delay
                    n_rem     = r_rem - i_rd_delta;
                    n_at_head = 1'b0;
                    n_cur     = i_rd_link;
                    n_seen    = w_seen_nx;
                    if (w_seen_nx == r_count) begin
                        // End of list: link the tail to the new entry
                        o_ctl.nw_en = 1'b1;
                        o_nw_addr   = r_cur;
                        o_nw_id     = i_rd_id;
                        o_nw_link   = r_slot;
                        n_state     = S_PLACE;
                    end else begin
                        n_prev      = r_cur;
                        n_prev_id   = i_rd_id;
                        o_ctl.rd_en = 1'b1;
                        o_rd_addr   = i_rd_link;
                    end
                end else begin
                    // Stop in front of this entry and shorten its delta
                    o_ctl.dw_en = 1'b1;
                    o_dw_addr   = r_cur;
                    o_dw_data   = i_rd_delta - r_rem;
                    if (!r_at_head) begin
                        o_ctl.nw_en = 1'b1;
                        o_nw_addr   = r_prev;
                        o_nw_id     = r_prev_id;
                        o_nw_link   = r_slot;
                    end
                    n_state = S_PLACE;
                end
            end

            S_PLACE: begin
                // Write the new entry and claim its slot
                o_ctl.dw_en = 1'b1;
                o_dw_addr   = r_slot;
                o_dw_data   = r_rem;
                o_ctl.nw_en = 1'b1;
                o_nw_addr   = r_slot;
                o_nw_id     = r_id;
                o_nw_link   = r_cur;
                if (r_at_head) begin
                    n_head = r_slot;
                end
                n_free[r_slot] = 1'b0;
                n_count        = r_count + CNT_W'(1);
                n_kind         = KIND_OK;
                n_state        = S_EMIT;
            end

            S_ADV: begin
                if (i_rd_delta > r_ticks) begin
                    // Nothing more due: reduce the head delta
                    o_ctl.dw_en = 1'b1;
                    o_dw_addr   = r_cur;
                    o_dw_data   = i_rd_delta - r_ticks;
                    n_kind      = KIND_FIRED;
                    n_state     = r_pend ? S_EMIT : S_IDLE;
                end else if (!r_pend || i_out_free) begin
                    // Fire the head; release the held result with last cleared
                    o_emit         = r_pend;
                    n_pend         = 1'b1;
                    n_pend_id      = i_rd_id;
                    n_ticks        = r_ticks - i_rd_delta;
                    n_free[r_cur]  = 1'b1;
                    n_count        = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_head  = '0;
                        n_kind  = KIND_FIRED;
                        n_state = S_EMIT;
                    end else begin
                        n_head      = i_rd_link;
                        n_cur       = i_rd_link;
                        o_ctl.rd_en = 1'b1;
                        o_rd_addr   = i_rd_link;
                    end
                end
            end

            S_EMIT: begin
                if (i_out_free) begin
                    o_emit      = 1'b1;
                    o_emit_item = '{kind: r_kind,
                                    fired_id: (r_kind == KIND_FIRED) ? r_pend_id : '0,
                                    last: 1'b1};
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_free  <= '1;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_free  <= n_free;
            r_pend  <= n_pend;
        end
    end

    // Working registers of the current request
    always_ff @(posedge i_clk) begin
        r_cur     <= n_cur;
        r_prev    <= n_prev;
        r_slot    <= n_slot;
        r_prev_id <= n_prev_id;
        r_id      <= n_id;
        r_pend_id <= n_pend_id;
        r_rem     <= n_rem;
        r_ticks   <= n_ticks;
        r_seen    <= n_seen;
        r_at_head <= n_at_head;
        r_kind    <= n_kind;
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_count    = r_count;
    assign o_free     = r_free;

endmodule

FILE: sv/delta_clock_event_queue_unit.sv
// Delta-clock event queue: request sequence and reset behavior.
// Insert: walk the list from the head, one entry read per cycle through the single
// read port, then place the new entry and emit its result; a full queue refuses it.
// Advance: fire due events from the head, then reduce the remaining head delta; zero
// ticks or an empty queue fire nothing. A stalled result holds the firing loop.
// Reset clears head, count and free map; entry memories are not cleared.
module delta_clock_event_queue_unit #(
    parameter int CAPACITY = dcq_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dcq_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dcq_pkg::t_out_item o_out_data
);
    import dcq_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_mem_ctl            w_ctl;
    logic [IDX_W-1:0]    w_rd_addr;
    logic [IDX_W-1:0]    w_dw_addr;
    t_delay              w_dw_data;
    logic [IDX_W-1:0]    w_nw_addr;
    t_id                 w_nw_id;
    logic [IDX_W-1:0]    w_nw_link;
    t_delay              w_rd_delta;
    t_id                 w_rd_id;
    logic [IDX_W-1:0]    w_rd_link;
    logic                w_emit;
    t_out_item           w_emit_item;
    logic                w_out_free;
    logic [CNT_W-1:0]    w_count;
    logic [CAPACITY-1:0] w_free;

    logic                r_out_valid;
    t_out_item           r_out_data;

    dcq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_free  (w_out_free),
        .o_emit      (w_emit),
        .o_emit_item (w_emit_item),
        .o_ctl       (w_ctl),
        .o_rd_addr   (w_rd_addr),
        .o_dw_addr   (w_dw_addr),
        .o_dw_data   (w_dw_data),
        .o_nw_addr   (w_nw_addr),
        .o_nw_id     (w_nw_id),
        .o_nw_link   (w_nw_link),
        .i_rd_delta  (w_rd_delta),
        .i_rd_id     (w_rd_id),
        .i_rd_link   (w_rd_link),
        .o_count     (w_count),
        .o_free      (w_free)
    );

    dcq_store #(.CAPACITY(CAPACITY)) u_store (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_rd_addr  (w_rd_addr),
        .i_dw_addr  (w_dw_addr),
        .i_dw_data  (w_dw_data),
        .i_nw_addr  (w_nw_addr),
        .i_nw_id    (w_nw_id),
        .i_nw_link  (w_nw_link),
        .o_rd_delta (w_rd_delta),
        .o_rd_id    (w_rd_id),
        .o_rd_link  (w_rd_link)
    );

    // Output register is free when empty or being taken this cycle
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Load a new result, or drop the one taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data <= w_emit_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Free map and entry count stay consistent
    a_count_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(w_free) + int'(w_count)) == CAPACITY)
        else $error("free map and entry count disagree");

    // A result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> w_out_free)
        else $error("result overwrites a pending result");

    // Insert results always close their request
    a_insert_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_emit_item.kind != KIND_FIRED) |-> w_emit_item.last)
        else $error("insert result without last");

endmodule
